>>> rtl/gvb_pkg.sv
package gvb_pkg;

    localparam int MAX_COLS  = 256;
    localparam int MAX_ROWS  = 256;
    localparam int FRAC_BITS = 16;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    // four banks split by column and row parity, each holds a quarter of the grid
    localparam int BANK_AW   = COL_W - 1 + ROW_W - 1;
    localparam int CELL_W    = 33;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] CFG_INV_CELL_X = 3'd2;
    localparam logic [2:0] CFG_INV_CELL_Y = 3'd3;
    localparam logic [2:0] CFG_GRID_COLS  = 3'd4;
    localparam logic [2:0] CFG_GRID_ROWS  = 3'd5;

    typedef struct packed {
        logic                 neg;
        logic [CELL_W-1:0]    idx;
        logic [FRAC_BITS-1:0] frac;
    } map_t;

    typedef struct packed {
        logic             wr;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [63:0]      data;
    } wr_req_t;

endpackage

>>> rtl/gvb_map.sv
module gvb_map
    import gvb_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] point,
    input  logic signed [31:0] origin,
    input  logic        [31:0] inv,
    output map_t               result
);

    logic signed [32:0] q_reg;
    logic [47:0]        a_reg;
    logic [47:0]        b_reg;
    logic               neg_reg;
    logic [48:0]        r;
    map_t               result_reg;

    assign r = {17'b0, a_reg[15:0], 16'b0} + {1'b0, b_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg   <= {point[31], point} - {origin[31], origin};
            // split into two 16 x 32 products
            a_reg   <= {32'b0, q_reg[31:16]} * {16'b0, inv};
            b_reg   <= {32'b0, q_reg[15:0]} * {16'b0, inv};
            neg_reg <= q_reg[32];
            result_reg.neg  <= neg_reg;
            result_reg.idx  <= {1'b0, a_reg[47:16]} + {16'b0, r[48:32]};
            result_reg.frac <= r[31:32-FRAC_BITS];
        end
    end

    assign result = result_reg;

endmodule

>>> rtl/gvb_store.sv
module gvb_store
    import gvb_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  wr_req_t          wreq,
    input  logic [COL_W-1:0] rd_col,
    input  logic [ROW_W-1:0] rd_row,
    output logic [3:0][63:0] rd_data
);

    logic [COL_W:0] col_up;
    logic [ROW_W:0] row_up;

    // even-parity banks serve the far corner when the cell index is odd
    assign col_up = {1'b0, rd_col} + 1'b1;
    assign row_up = {1'b0, rd_row} + 1'b1;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic [1:0] BID = 2'(b);

        logic [63:0]        mem [2**BANK_AW];
        logic [BANK_AW-1:0] waddr;
        logic [BANK_AW-1:0] raddr;
        logic [63:0]        rdata_reg;
        logic               hit;

        assign waddr = {wreq.row[ROW_W-1:1], wreq.col[COL_W-1:1]};
        assign raddr = {(BID[1] ? rd_row[ROW_W-1:1] : row_up[ROW_W-1:1]),
                        (BID[0] ? rd_col[COL_W-1:1] : col_up[COL_W-1:1])};
        assign hit   = wreq.wr && (wreq.row[0] == BID[1]) && (wreq.col[0] == BID[0]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (hit)
                begin
                    mem[waddr] <= wreq.data;
                end
                rdata_reg <= mem[raddr];
            end
        end

        assign rd_data[b] = rdata_reg;
    end

endmodule

>>> rtl/gvb_lerp.sv
module gvb_lerp
    import gvb_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [31:0]   a,
    input  logic signed [31:0]   b,
    input  logic [FRAC_BITS-1:0] f,
    output logic signed [31:0]   y
);

    logic signed [32:0]           d;
    logic signed [FRAC_BITS+33:0] prod_reg;
    logic signed [31:0]           a_reg;
    logic signed [31:0]           y_reg;

    assign d = {b[31], b} - {a[31], a};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= d * $signed({1'b0, f});
            a_reg    <= a;
            // arithmetic shift is the floor; the sum always fits 32 bits
            y_reg    <= a_reg + prod_reg[FRAC_BITS+31:FRAC_BITS];
        end
    end

    assign y = y_reg;

endmodule

>>> rtl/grid_vector_bilinear_sampler_top.sv
// Bilinear sampler over a 256 x 256 grid of Q16.16 vector pairs. One item (grid write or
// point query) is taken every cycle while item_stall is low. The store is four banks, each
// with one write and one read port, split by column and row parity, so the four corners of
// a cell come from four different banks in one read.
// Writes reach the store at the same pipeline stage where queries read it, so every query
// sees exactly the writes that came before it. The store is not cleared: an entry must be
// written before any query touches it. Points below the origin or in a cell without its
// far corners return zero with in_range low. Configuration may change only while idle.
module grid_vector_bilinear_sampler_top
    import gvb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic               command,
    input  logic [7:0]         col_index,
    input  logic [7:0]         row_index,
    input  logic signed [31:0] entry_x,
    input  logic signed [31:0] entry_y,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] sample_x,
    output logic signed [31:0] sample_y,
    output logic               in_range,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic signed [31:0] origin_x_reg, origin_y_reg;
    logic [31:0]        inv_cell_x_reg, inv_cell_y_reg;
    logic [8:0]         grid_cols_reg, grid_rows_reg;

    logic en;
    logic accept;

    logic [3:0]         v_reg;
    logic [3:0]         cmd_reg;
    logic [3:0][7:0]    col_reg;
    logic [3:0][7:0]    row_reg;
    logic [3:0][63:0]   ent_reg;
    logic signed [31:0] px_reg, py_reg;

    logic [8:4]                vq_reg;
    logic [8:4]                rng_reg;
    logic [6:4][FRAC_BITS-1:0] fv_reg;
    logic [FRAC_BITS-1:0]      fu_reg;
    logic                      c0_reg, r0_reg;

    map_t    mx, my;
    wr_req_t wreq;
    logic [3:0][63:0] bank_data;
    logic [8:0] cols_used, rows_used;
    logic       ok;

    logic [63:0] c00, c10, c01, c11;
    logic signed [31:0] x0, x1, y0, y1, rx, ry;

    assign en         = !(result_valid && result_stall);
    assign item_stall = !en;
    assign accept     = item_valid && en;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            inv_cell_x_reg <= 32'd65536;
            inv_cell_y_reg <= 32'd65536;
            grid_cols_reg  <= 9'd256;
            grid_rows_reg  <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X:   origin_x_reg   <= cfg_data;
                CFG_ORIGIN_Y:   origin_y_reg   <= cfg_data;
                CFG_INV_CELL_X: inv_cell_x_reg <= cfg_data;
                CFG_INV_CELL_Y: inv_cell_y_reg <= cfg_data;
                CFG_GRID_COLS:  grid_cols_reg  <= cfg_data[8:0];
                CFG_GRID_ROWS:  grid_rows_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            vq_reg  <= '0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[2:0], accept};
            vq_reg <= {vq_reg[7:4], v_reg[3] && (cmd_reg[3] == CMD_QUERY)};
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_reg <= {cmd_reg[2:0], command};
            col_reg <= {col_reg[2:0], col_index};
            row_reg <= {row_reg[2:0], row_index};
            ent_reg <= {ent_reg[2:0], entry_y, entry_x};
            px_reg  <= point_x;
            py_reg  <= point_y;
            rng_reg <= {rng_reg[7:4], ok};
            fu_reg  <= mx.frac;
            fv_reg  <= {fv_reg[5:4], my.frac};
            c0_reg  <= mx.idx[0];
            r0_reg  <= my.idx[0];
        end
    end

    gvb_map u_map_x (
        .clk    (clk),
        .en     (en),
        .point  (px_reg),
        .origin (origin_x_reg),
        .inv    (inv_cell_x_reg),
        .result (mx)
    );

    gvb_map u_map_y (
        .clk    (clk),
        .en     (en),
        .point  (py_reg),
        .origin (origin_y_reg),
        .inv    (inv_cell_y_reg),
        .result (my)
    );

    assign cols_used = (grid_cols_reg > 9'(MAX_COLS)) ? 9'(MAX_COLS) : grid_cols_reg;
    assign rows_used = (grid_rows_reg > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : grid_rows_reg;

    always_comb
    begin
        ok = !mx.neg && !my.neg && (cols_used >= 9'd2) && (rows_used >= 9'd2)
             && (mx.idx <= {24'b0, cols_used - 9'd2})
             && (my.idx <= {24'b0, rows_used - 9'd2});
    end

    assign wreq.wr   = v_reg[3] && (cmd_reg[3] == CMD_WRITE);
    assign wreq.col  = col_reg[3];
    assign wreq.row  = row_reg[3];
    assign wreq.data = ent_reg[3];

    gvb_store u_store (
        .clk     (clk),
        .en      (en),
        .wreq    (wreq),
        .rd_col  (mx.idx[COL_W-1:0]),
        .rd_row  (my.idx[ROW_W-1:0]),
        .rd_data (bank_data)
    );

    // bank index is {row parity, column parity}
    assign c00 = bank_data[{r0_reg, c0_reg}];
    assign c10 = bank_data[{r0_reg, !c0_reg}];
    assign c01 = bank_data[{!r0_reg, c0_reg}];
    assign c11 = bank_data[{!r0_reg, !c0_reg}];

    gvb_lerp u_lx0 (.clk(clk), .en(en), .a(c00[31:0]), .b(c10[31:0]), .f(fu_reg), .y(x0));
    gvb_lerp u_lx1 (.clk(clk), .en(en), .a(c01[31:0]), .b(c11[31:0]), .f(fu_reg), .y(x1));
    gvb_lerp u_ly0 (.clk(clk), .en(en), .a(c00[63:32]), .b(c10[63:32]), .f(fu_reg), .y(y0));
    gvb_lerp u_ly1 (.clk(clk), .en(en), .a(c01[63:32]), .b(c11[63:32]), .f(fu_reg), .y(y1));
    gvb_lerp u_lvx (.clk(clk), .en(en), .a(x0), .b(x1), .f(fv_reg[6]), .y(rx));
    gvb_lerp u_lvy (.clk(clk), .en(en), .a(y0), .b(y1), .f(fv_reg[6]), .y(ry));

    assign result_valid = vq_reg[8];
    assign in_range     = rng_reg[8];
    assign sample_x     = rng_reg[8] ? rx : '0;
    assign sample_y     = rng_reg[8] ? ry : '0;

    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("input stalled without a waiting result");

    a_query_reaches_store: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v_reg[3] && (cmd_reg[3] == CMD_QUERY)) |=> vq_reg[4])
        else $error("query lost at store stage");

    a_no_write_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vq_reg) && $stable(v_reg))
        else $error("pipeline moved while stalled");

endmodule
